// ===== rtl/pdtt_pkg.sv =====
// Shared types and constants for the partition deadline timer table.
package pdtt_pkg;

	localparam int PARTITIONS_DEF = 16;

	localparam int PART_W = 8;
	localparam int TIME_W = 64;

	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_CHECK  = 2'd1,
		CMD_ACK    = 2'd2,
		CMD_CANCEL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_PERM  = 2'd2,
		ST_NOSPC = 2'd3
	} status_t;

endpackage

// ===== rtl/partition_deadline_timer_table_top.sv =====
// Partition deadline timer table: command sequencer, deadline memory and earliest-deadline scan.
// After a request is accepted, the sequencer steps through read, execute, scan and drain; m_axis_tvalid rises in done.
// No new request is taken until the result has been handed over; the scan reads one table
// entry per cycle through the single read port of the deadline memory, and the deadline
// check and the scan comparisons go through one shared 64-bit comparator.
// Reset (arst_n low) clears all active and expired marks, so the table starts empty.
module partition_deadline_timer_table_top
	import pdtt_pkg::*;
#(
	parameter int PARTITIONS = PARTITIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] partition, [71:8] deadline_time, [135:72] current_time
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] command
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [2] has_expired, [3] earliest_valid, [67:4] earliest_deadline, [71:68] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (PARTITIONS > 2) ? $clog2(PARTITIONS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;

	// request payload
	cmd_t              cmd_q;
	logic [PART_W-1:0] part_q;
	logic [TIME_W-1:0] dl_q;
	logic [TIME_W-1:0] now_q;

	logic [PARTITIONS-1:0] active_q;
	logic [PARTITIONS-1:0] expired_q;

	logic [TIME_W-1:0] mem_q [PARTITIONS];
	logic [TIME_W-1:0] rd_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             pend_q;
	logic [IDX_W-1:0] pend_idx_q;

	status_t           status_q;
	logic              hit_q;
	logic              any_q;
	logic [TIME_W-1:0] best_q;

	logic [IDX_W-1:0]  idx;
	logic              part_ok;
	logic [IDX_W-1:0]  rd_addr;
	logic [TIME_W-1:0] cmp_a;
	logic [TIME_W-1:0] cmp_b;
	logic              cmp_lt;
	logic              act;
	logic              exp;
	status_t           ex_status;
	logic              ex_hit;
	logic              ex_set;
	logic              ex_clear;
	logic              ex_expire;
	logic              take;
	logic              scan_last;

	assign idx     = part_q[IDX_W-1:0];
	assign part_ok = (part_q != '0) && ({1'b0, part_q} < 9'(PARTITIONS));
	assign act     = active_q[idx];
	assign exp     = expired_q[idx];

	assign rd_addr = (state_q == S_SCAN) ? scan_idx_q : (part_ok ? idx : '0);

	// shared comparator: time against deadline during execute, candidate against best in the scan
	assign cmp_a  = (state_q == S_EXEC) ? now_q : rd_q;
	assign cmp_b  = (state_q == S_EXEC) ? rd_q : best_q;
	assign cmp_lt = cmp_a < cmp_b;

	assign scan_last = scan_idx_q == IDX_W'(PARTITIONS - 1);
	assign take      = pend_q && active_q[pend_idx_q] && (!any_q || cmp_lt);

	always_comb begin
		ex_status = ST_OK;
		ex_hit    = 1'b0;
		ex_set    = 1'b0;
		ex_clear  = 1'b0;
		ex_expire = 1'b0;
		if (!part_ok) begin
			ex_status = ST_INVAL;
		end else begin
			case (cmd_q)
				CMD_SET: begin
					if (dl_q == '0)
						ex_status = ST_INVAL;
					else if (act && exp)
						ex_status = ST_PERM;
					else if (act)
						ex_status = ST_NOSPC;
					else
						ex_set = 1'b1;
				end
				CMD_CHECK: begin
					if (now_q == '0) begin
						ex_status = ST_INVAL;
					end else if (!act) begin
						ex_status = ST_PERM;
					end else if (!cmp_lt) begin
						ex_expire = 1'b1;
						ex_hit    = 1'b1;
					end
				end
				CMD_ACK: begin
					if (!act || !exp)
						ex_status = ST_PERM;
					else
						ex_clear = 1'b1;
				end
				CMD_CANCEL: begin
					if (!act || exp)
						ex_status = ST_PERM;
					else
						ex_clear = 1'b1;
				end
				default: ex_status = ST_INVAL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && ex_set)
			mem_q[idx] <= dl_q;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q  <= cmd_t'(s_axis_tuser);
			part_q <= s_axis_tdata[PART_W-1:0];
			dl_q   <= s_axis_tdata[PART_W +: TIME_W];
			now_q  <= s_axis_tdata[PART_W + TIME_W +: TIME_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			expired_q  <= '0;
			scan_idx_q <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			status_q   <= ST_OK;
			hit_q      <= 1'b0;
			any_q      <= 1'b0;
			best_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					status_q <= ex_status;
					hit_q    <= ex_hit;
					if (ex_set) begin
						active_q[idx]  <= 1'b1;
						expired_q[idx] <= 1'b0;
					end
					if (ex_clear) begin
						active_q[idx]  <= 1'b0;
						expired_q[idx] <= 1'b0;
					end
					if (ex_expire)
						expired_q[idx] <= 1'b1;
					// partition 0 is reserved, so the scan starts at entry 1
					scan_idx_q <= IDX_W'(1);
					pend_q     <= 1'b0;
					any_q      <= 1'b0;
					best_q     <= '0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (take) begin
						any_q  <= 1'b1;
						best_q <= rd_q;
					end
					pend_q     <= 1'b1;
					pend_idx_q <= scan_idx_q;
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (take) begin
						any_q  <= 1'b1;
						best_q <= rd_q;
					end
					pend_q  <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = state_q == S_DONE;
	assign m_axis_tdata  = {4'b0, best_q, any_q, hit_q, status_q};

endmodule

// ===== test/tb_partition_deadline_timer_table_top.sv =====
// Testbench for the partition deadline timer table: scoreboard, stream drivers and checks.
module tb_partition_deadline_timer_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pdtt_pkg::*;

	localparam int PARTS       = PARTITIONS_DEF;
	localparam int REPORT_CAP  = 30;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS_PER_PHASE = 100;

	typedef struct {
		status_t           status;
		bit                has_expired;
		bit                earliest_valid;
		bit [TIME_W-1:0]   earliest_deadline;
	} timer_reply_t;

	class deadline_scoreboard;
		bit [TIME_W-1:0] deadline_of [PARTS];
		bit              armed [PARTS];
		bit              fired [PARTS];
		timer_reply_t    replies_due [$];
		int unsigned     mismatches;

		task report(string what);
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		function int pending();
			return replies_due.size();
		endfunction

		// Apply one accepted request to the table copy and queue the reply it should give.
		function void note_request(cmd_t cmd, bit [PART_W-1:0] part,
				bit [TIME_W-1:0] deadline, bit [TIME_W-1:0] now);
			timer_reply_t r;
			r.status            = ST_OK;
			r.has_expired       = 1'b0;
			r.earliest_valid    = 1'b0;
			r.earliest_deadline = '0;
			if (part == 0 || part >= PARTS) begin
				r.status = ST_INVAL;
			end else begin
				case (cmd)
					CMD_SET: begin
						if (deadline == 0)
							r.status = ST_INVAL;
						else if (armed[part] && fired[part])
							r.status = ST_PERM;
						else if (armed[part])
							r.status = ST_NOSPC;
						else begin
							deadline_of[part] = deadline;
							armed[part]       = 1'b1;
							fired[part]       = 1'b0;
						end
					end
					CMD_CHECK: begin
						if (now == 0)
							r.status = ST_INVAL;
						else if (!armed[part])
							r.status = ST_PERM;
						else if (now >= deadline_of[part]) begin
							fired[part]   = 1'b1;
							r.has_expired = 1'b1;
						end
					end
					CMD_ACK: begin
						if (!armed[part] || !fired[part])
							r.status = ST_PERM;
						else begin
							deadline_of[part] = '0;
							armed[part]       = 1'b0;
							fired[part]       = 1'b0;
						end
					end
					default: begin
						// cancel is only allowed while still pending
						if (!armed[part] || fired[part])
							r.status = ST_PERM;
						else begin
							deadline_of[part] = '0;
							armed[part]       = 1'b0;
							fired[part]       = 1'b0;
						end
					end
				endcase
			end
			for (int i = 1; i < PARTS; i++) begin
				if (armed[i] && (!r.earliest_valid || deadline_of[i] < r.earliest_deadline)) begin
					r.earliest_deadline = deadline_of[i];
					r.earliest_valid    = 1'b1;
				end
			end
			replies_due.push_back(r);
		endfunction

		task check_result(logic [OUT_TDATA_W-1:0] tdata);
			timer_reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("result with nothing outstanding: %h", tdata));
				return;
			end
			want = replies_due.pop_front();
			if (tdata[1:0] !== want.status)
				report($sformatf("status %b, want %s", tdata[1:0], want.status.name()));
			if (tdata[2] !== want.has_expired)
				report($sformatf("has_expired %b, want %b", tdata[2], want.has_expired));
			if (tdata[3] !== want.earliest_valid)
				report($sformatf("earliest_valid %b, want %b", tdata[3], want.earliest_valid));
			if (tdata[67:4] !== want.earliest_deadline)
				report($sformatf("earliest_deadline %h, want %h", tdata[67:4],
					want.earliest_deadline));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [1:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	deadline_scoreboard sb = new;

	int          send_idle_pct  = 0;
	int          stall_pct      = 0;
	int unsigned requests_taken = 0;
	int unsigned hold_left      = 0;
	bit          hold_done      = 1'b0;
	bit [TIME_W-1:0] epoch;

	partition_deadline_timer_table_top #(.PARTITIONS(PARTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: random stalls, plus one long hold-off once traffic is flowing.
	always @(negedge clk) begin
		if (!hold_done && requests_taken >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else
			m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	function automatic bit [TIME_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Offer one request from a falling edge and return at the falling edge after it is taken.
	task automatic send_request(cmd_t cmd, bit [PART_W-1:0] part,
			bit [TIME_W-1:0] deadline, bit [TIME_W-1:0] now);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {now, deadline, part};
		s_axis_tuser  = cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(cmd, part, deadline, now);
		requests_taken++;
		@(negedge clk);
	endtask

	task automatic run_directed();
		bit [TIME_W-1:0] top;
		top = '1;
		send_request(CMD_SET, 8'd0, 64'd5, rand64());
		send_request(CMD_CHECK, 8'd16, rand64(), 64'd5);
		send_request(CMD_ACK, 8'd255, rand64(), rand64());
		send_request(CMD_CANCEL, 8'd0, rand64(), rand64());
		send_request(CMD_SET, 8'd1, 64'd0, rand64());
		send_request(CMD_SET, 8'd1, top, rand64());
		send_request(CMD_SET, 8'd1, 64'd7, rand64());
		send_request(CMD_CHECK, 8'd1, rand64(), 64'd0);
		send_request(CMD_CHECK, 8'd1, rand64(), top - 1);
		send_request(CMD_ACK, 8'd1, rand64(), rand64());
		send_request(CMD_CHECK, 8'd1, rand64(), top);
		send_request(CMD_SET, 8'd1, 64'd3, rand64());
		send_request(CMD_CANCEL, 8'd1, rand64(), rand64());
		// expiry stays latched although time is now before the deadline
		send_request(CMD_CHECK, 8'd1, rand64(), 64'd1);
		send_request(CMD_ACK, 8'd1, rand64(), rand64());
		send_request(CMD_ACK, 8'd1, rand64(), rand64());
		send_request(CMD_CHECK, 8'd2, rand64(), 64'd1);
		send_request(CMD_CANCEL, 8'd2, rand64(), rand64());
		send_request(CMD_SET, 8'd15, 64'd1, rand64());
		send_request(CMD_SET, 8'd7, 64'h8000_0000_0000_0000, rand64());
		send_request(CMD_CHECK, 8'd15, rand64(), 64'd1);
		send_request(CMD_CANCEL, 8'd7, rand64(), rand64());
		send_request(CMD_ACK, 8'd15, rand64(), rand64());
		send_request(CMD_CHECK, 8'd0, rand64(), 64'd0);
	endtask

	// Mostly legal commands around a drifting time base; the rest is noise.
	task automatic run_random(int count);
		cmd_t            cmd;
		bit [PART_W-1:0] part;
		bit [TIME_W-1:0] deadline;
		bit [TIME_W-1:0] now;
		int              pick;
		epoch = rand64() >> $urandom_range(1, 40);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				cmd      = cmd_t'($urandom_range(0, 3));
				part     = PART_W'($urandom_range(0, 255));
				deadline = ($urandom_range(0, 9) == 0) ? '0 : rand64();
				now      = ($urandom_range(0, 9) == 0) ? '0 : rand64();
			end else begin
				part = PART_W'($urandom_range(1, PARTS - 1));
				pick = $urandom_range(0, 99);
				if (pick < 35)
					cmd = CMD_SET;
				else if (pick < 70)
					cmd = CMD_CHECK;
				else if (pick < 85)
					cmd = CMD_ACK;
				else
					cmd = CMD_CANCEL;
				deadline = epoch + $urandom_range(1, 3000);
				now      = epoch + $urandom_range(0, 3000);
				epoch    = epoch + $urandom_range(0, 40);
			end
			send_request(cmd, part, deadline, now);
		end
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_SET;
		arst_n        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			run_random(RANDOM_ITEMS_PER_PHASE);
		end
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// catch any stray result after the last one due
		repeat (4 * PARTS) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pdtt_pkg.sv
rtl/partition_deadline_timer_table_top.sv
test/tb_partition_deadline_timer_table_top.sv
